FILE: design/xudr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xudr_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = WORD_W / 2;
   localparam int FACE_W = 17;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [HALF_W-1:0] half_type;
   typedef logic [FACE_W-1:0] face_type;

   localparam word_type DEFAULT_SEED = 64'h0123456789ABCDEF;
   localparam word_type SM_GAMMA     = 64'h9E3779B97F4A7C15;
   localparam word_type SM_MUL1      = 64'hBF58476D1CE4E5B9;
   localparam word_type SM_MUL2      = 64'h94D049BB133111EB;

   localparam int SM_SHR0 = 30;
   localparam int SM_SHR1 = 27;
   localparam int SM_SHR2 = 31;

   localparam int ROT_A = 55;
   localparam int ROT_B = 36;
   localparam int SHL_B = 14;

   // remainder unit retires two dividend bits per cycle
   localparam int DIV_STEPS = WORD_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic OP_ROLL   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SM_ADD,
      ST_SM_MUL1,
      ST_SM_MUL2,
      ST_ROLL_LIM,
      ST_ROLL_DRAW,
      ST_ROLL_MOD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      face_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      face_type remainder;
   } div_rsp_type;

   function automatic word_type rotl(word_type v, int n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic word_type xoro_next_low(word_type a, word_type b);
      word_type t;
      t = b ^ a;
      xoro_next_low = rotl(a, ROT_A) ^ t ^ (t << SHL_B);
   endfunction

   function automatic word_type xoro_next_high(word_type a, word_type b);
      word_type t;
      t = b ^ a;
      xoro_next_high = rotl(t, ROT_B);
   endfunction

endpackage

`default_nettype wire

FILE: design/xudr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface xudr_req_if;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   xudr_pkg::word_type       seed_value;
   xudr_pkg::face_type       face_count;

   modport source (output valid, output operation, output seed_value, output face_count,
                   input ready);
   modport sink (input valid, input operation, input seed_value, input face_count,
                 output ready);
endinterface

`default_nettype wire

FILE: design/xudr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface xudr_rsp_if;
   logic                     valid;
   logic                     ready;
   xudr_pkg::face_type       face_value;

   modport source (output valid, output face_value, input ready);
   modport sink (input valid, input face_value, output ready);
endinterface

`default_nettype wire

FILE: design/xudr_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// 32x32 multiplier with registered product
module xudr_mul (
   input  logic                clock,
   input  xudr_pkg::half_type  mul_a,
   input  xudr_pkg::half_type  mul_b,
   output xudr_pkg::word_type  product
);

   xudr_pkg::word_type prod_ff;
   xudr_pkg::word_type prod_in;

   always_comb begin
      prod_in = xudr_pkg::WORD_W'(mul_a) * xudr_pkg::WORD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

FILE: design/xudr_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// radix-4 restoring remainder, 64-bit dividend by 17-bit divisor
module xudr_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  xudr_pkg::div_req_type div_req,
   output xudr_pkg::div_rsp_type div_rsp
);

   localparam logic [xudr_pkg::DIV_CNT_W-1:0] CNT_LAST =
      xudr_pkg::DIV_CNT_W'(xudr_pkg::DIV_STEPS - 1);

   xudr_pkg::word_type dvd_ff, dvd_in;
   xudr_pkg::face_type dsr_ff, dsr_in;
   xudr_pkg::face_type rem_ff, rem_in;
   logic [xudr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic done_ff, done_in;

   function automatic xudr_pkg::face_type rem_step(xudr_pkg::face_type r, logic b,
                                                   xudr_pkg::face_type d);
      logic [xudr_pkg::FACE_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         rem_step = xudr_pkg::FACE_W'(t - {1'b0, d});
      end else begin
         rem_step = t[xudr_pkg::FACE_W-1:0];
      end
   endfunction

   always_comb begin
      xudr_pkg::face_type r1;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      r1      = rem_step(rem_ff, dvd_ff[xudr_pkg::WORD_W-1], dsr_ff);
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         dsr_in = div_req.divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = rem_step(r1, dvd_ff[xudr_pkg::WORD_W-2], dsr_ff);
         dvd_in = dvd_ff << 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

FILE: design/xoroshiro_unbiased_die_roller.sv
`timescale 1ns / 1ps
`default_nettype none
// roll: the time from acceptance to result is set by two passes of the radix-4 remainder unit,
//   a limit pass and a modulo pass, and grows with each rejected draw
// reseed: two splitmix64 rounds, each an add state and the SM_MUL1 and SM_MUL2 states on a 32x32 multiplier
// counts of zero and one: result goes through the finish state to the response register; one transaction at a time
// reset (synchronous, active high) starts a seeding run from the default seed,
//   during which req ready stays low and no response is produced
module xoroshiro_unbiased_die_roller (
   input logic        clock,
   input logic        reset,
   xudr_req_if.sink   req_chan,
   xudr_rsp_if.source rsp_chan
);

   localparam logic [1:0] PHASE_LAST = 2'd3;

   xudr_pkg::state_type state_ff, state_in;

   // generator state and splitmix working registers
   xudr_pkg::word_type s0_ff, s0_in;
   xudr_pkg::word_type s1_ff, s1_in;
   xudr_pkg::word_type acc_ff, acc_in;     // splitmix counter
   xudr_pkg::word_type opnd_ff, opnd_in;   // multiplicand of the current mix step
   xudr_pkg::word_type sum_ff, sum_in;     // partial product sum
   logic [1:0]         phase_ff, phase_in;
   logic               draw_ff, draw_in;   // second splitmix output in progress
   logic               init_ff, init_in;   // seeding run after reset, no response

   // roll registers
   xudr_pkg::face_type faces_ff, faces_in;
   xudr_pkg::word_type limit_ff, limit_in;
   xudr_pkg::face_type res_ff, res_in;

   // response register
   logic               out_valid_ff, out_valid_in;
   xudr_pkg::face_type out_data_ff, out_data_in;

   logic               accept;
   logic               out_free;
   xudr_pkg::word_type draw_sum;
   logic               draw_ok;
   xudr_pkg::word_type mix_final;
   xudr_pkg::word_type mul_const;
   xudr_pkg::half_type mul_a, mul_b;
   xudr_pkg::word_type mul_prod;

   xudr_pkg::div_req_type div_req;
   xudr_pkg::div_rsp_type div_rsp;

   xudr_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_prod)
   );

   xudr_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept   = req_chan.valid && (state_ff == xudr_pkg::ST_IDLE);
   assign out_free = !out_valid_ff || rsp_chan.ready;

   // xoroshiro128+ output and the rejection test share this cycle
   assign draw_sum = s0_ff + s1_ff;
   assign draw_ok  = draw_sum < limit_ff;

   // 64x64 low product from three 32x32 partials: lo*lo, lo*hi, hi*lo
   assign mix_final = sum_ff + {mul_prod[xudr_pkg::HALF_W-1:0], xudr_pkg::half_type'(0)};
   assign mul_const = (state_ff == xudr_pkg::ST_SM_MUL2) ? xudr_pkg::SM_MUL2
                                                         : xudr_pkg::SM_MUL1;
   assign mul_a = phase_ff[1] ? opnd_ff[xudr_pkg::WORD_W-1:xudr_pkg::HALF_W]
                              : opnd_ff[xudr_pkg::HALF_W-1:0];
   assign mul_b = (phase_ff == 2'd1) ? mul_const[xudr_pkg::WORD_W-1:xudr_pkg::HALF_W]
                                     : mul_const[xudr_pkg::HALF_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xudr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_chan.operation == xudr_pkg::OP_RESEED) begin
                  state_in = xudr_pkg::ST_SM_ADD;
               end else if (req_chan.face_count <= xudr_pkg::face_type'(1)) begin
                  state_in = xudr_pkg::ST_FINISH;
               end else begin
                  state_in = xudr_pkg::ST_ROLL_LIM;
               end
            end
         end
         xudr_pkg::ST_SM_ADD: begin
            state_in = xudr_pkg::ST_SM_MUL1;
         end
         xudr_pkg::ST_SM_MUL1: begin
            if (phase_ff == PHASE_LAST) begin
               state_in = xudr_pkg::ST_SM_MUL2;
            end
         end
         xudr_pkg::ST_SM_MUL2: begin
            if (phase_ff == PHASE_LAST) begin
               if (!draw_ff) begin
                  state_in = xudr_pkg::ST_SM_ADD;
               end else if (init_ff) begin
                  state_in = xudr_pkg::ST_IDLE;
               end else begin
                  state_in = xudr_pkg::ST_FINISH;
               end
            end
         end
         xudr_pkg::ST_ROLL_LIM: begin
            if (div_rsp.done) begin
               state_in = xudr_pkg::ST_ROLL_DRAW;
            end
         end
         xudr_pkg::ST_ROLL_DRAW: begin
            if (draw_ok) begin
               state_in = xudr_pkg::ST_ROLL_MOD;
            end
         end
         xudr_pkg::ST_ROLL_MOD: begin
            if (div_rsp.done) begin
               state_in = xudr_pkg::ST_FINISH;
            end
         end
         xudr_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = xudr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xudr_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      xudr_pkg::word_type acc_sum;
      xudr_pkg::word_type sm_out;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      acc_in       = acc_ff;
      opnd_in      = opnd_ff;
      sum_in       = sum_ff;
      phase_in     = phase_ff;
      draw_in      = draw_ff;
      init_in      = init_ff;
      faces_in     = faces_ff;
      limit_in     = limit_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_data_in  = out_data_ff;
      acc_sum      = acc_ff + xudr_pkg::SM_GAMMA;
      sm_out       = mix_final ^ (mix_final >> xudr_pkg::SM_SHR2);

      div_req.start    = 1'b0;
      div_req.dividend = draw_sum;
      div_req.divisor  = faces_ff;

      unique case (state_ff)
         xudr_pkg::ST_IDLE: begin
            // limit pass starts right at acceptance: remainder of all ones
            div_req.dividend = '1;
            div_req.divisor  = req_chan.face_count;
            if (accept) begin
               if (req_chan.operation == xudr_pkg::OP_RESEED) begin
                  acc_in  = (req_chan.seed_value != '0) ? req_chan.seed_value
                                                        : xudr_pkg::DEFAULT_SEED;
                  draw_in = 1'b0;
                  res_in  = '0;
               end else begin
                  faces_in = req_chan.face_count;
                  // zero and one faces answer with the count itself
                  res_in   = req_chan.face_count;
                  div_req.start = (req_chan.face_count > xudr_pkg::face_type'(1));
               end
            end
         end
         xudr_pkg::ST_SM_ADD: begin
            acc_in   = acc_sum;
            opnd_in  = acc_sum ^ (acc_sum >> xudr_pkg::SM_SHR0);
            phase_in = '0;
         end
         xudr_pkg::ST_SM_MUL1, xudr_pkg::ST_SM_MUL2: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == 2'd1) begin
               sum_in = mul_prod;
            end else if (phase_ff == 2'd2) begin
               sum_in = mix_final;
            end
            if (phase_ff == PHASE_LAST) begin
               if (state_ff == xudr_pkg::ST_SM_MUL1) begin
                  opnd_in = mix_final ^ (mix_final >> xudr_pkg::SM_SHR1);
               end else if (!draw_ff) begin
                  s0_in   = sm_out;
                  draw_in = 1'b1;
               end else begin
                  // an all-zero state would lock the generator
                  s1_in   = ((s0_ff == '0) && (sm_out == '0)) ? xudr_pkg::word_type'(1)
                                                              : sm_out;
                  draw_in = 1'b0;
                  init_in = 1'b0;
               end
            end
         end
         xudr_pkg::ST_ROLL_LIM: begin
            if (div_rsp.done) begin
               limit_in = '1 - xudr_pkg::WORD_W'(div_rsp.remainder);
            end
         end
         xudr_pkg::ST_ROLL_DRAW: begin
            s0_in = xudr_pkg::xoro_next_low(s0_ff, s1_ff);
            s1_in = xudr_pkg::xoro_next_high(s0_ff, s1_ff);
            div_req.start = draw_ok;
         end
         xudr_pkg::ST_ROLL_MOD: begin
            if (div_rsp.done) begin
               res_in = div_rsp.remainder + 1'b1;
            end
         end
         xudr_pkg::ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // reset seeds from the default seed through the normal splitmix path
         state_ff     <= xudr_pkg::ST_SM_ADD;
         acc_ff       <= xudr_pkg::DEFAULT_SEED;
         draw_ff      <= 1'b0;
         init_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         draw_ff      <= draw_in;
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      opnd_ff     <= opnd_in;
      sum_ff      <= sum_in;
      phase_ff    <= phase_in;
      faces_ff    <= faces_in;
      limit_ff    <= limit_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   assign req_chan.ready      = (state_ff == xudr_pkg::ST_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.face_value = out_data_ff;

endmodule

`default_nettype wire

FILE: design/xudr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module xudr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input xudr_pkg::face_type rsp_face_value
);

   // a pending response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_face_value))
      else $error("response changed while stalled");

   // one transaction in flight: ready drops right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // seeding after reset keeps the request side closed
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready && !rsp_valid)
      else $error("ready or response right after reset");

endmodule

bind xoroshiro_unbiased_die_roller xudr_checker u_xudr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_face_value (rsp_chan.face_value)
);

`default_nettype wire
